>>> hw/rtl/motor_speed_incremental_pid_macros.svh
// Assertion macros for the motor speed incremental PID block.
`ifndef MOTOR_SPEED_INCREMENTAL_PID_MACROS_SVH
`define MOTOR_SPEED_INCREMENTAL_PID_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define MSIP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked through reset.
`define MSIP_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/msip_pkg.sv
// Types and constants shared by the motor speed incremental PID block.
`timescale 1ns / 1ps
package msip_pkg;

  localparam int GAIN_W    = 16;
  localparam int TGT_W     = 16;
  localparam int LIMIT_W   = 16;
  localparam int DIV_W     = 8;
  localparam int PWM_W     = 16;
  localparam int CFG_DW    = 16;
  localparam int CFG_IW    = 3;
  localparam int ERR_W     = 22;
  localparam int FRAC_BITS = 12;
  localparam int ACC_W     = 30;
  localparam int STEP_W    = 42;
  localparam int SUM_W     = 43;
  localparam int ERR_MAX   = 2097151;
  localparam int ERR_MIN   = -2097152;
  localparam int MEAS_SCALE = 25;

  localparam logic signed [GAIN_W-1:0] GAIN_PROP_RST  = 16'sd8192;
  localparam logic signed [GAIN_W-1:0] GAIN_INTEG_RST = 16'sd0;
  localparam logic signed [GAIN_W-1:0] GAIN_DERIV_RST = 16'sd41;
  localparam logic [LIMIT_W-1:0]       LIMIT_RST      = 16'd10000;
  localparam logic [DIV_W-1:0]         DIV_RST        = 8'd10;

  typedef enum logic [CFG_IW-1:0] {
    CFG_GAIN_PROP  = 3'd0,
    CFG_GAIN_INTEG = 3'd1,
    CFG_GAIN_DERIV = 3'd2,
    CFG_DRIVE_LIM  = 3'd3,
    CFG_UPD_DIV    = 3'd4
  } cfg_idx_t;

endpackage

>>> hw/rtl/motor_speed_incremental_pid.sv
// Motor speed incremental PID controller with tick prescaler, top level.
//
// Input channel (in_valid/in_ready): one request per control tick with the
// encoder count, the speed setpoint and the park flag. Every update_divider-th
// tick (a divider of zero acts as one) runs the controller and yields one
// result on the output channel (out_valid/out_ready): forward and reverse PWM
// duty. Other ticks only advance the tick phase and yield nothing.
// A controller tick's request loads the input register when accepted, then
// passes the error, multiply, sum and accumulate/clamp stages into the output
// register. Throughput: one request per cycle unless the output stalls; the
// drive accumulator loop closes within the final stage, so back-to-back
// controller ticks run at full rate.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready and
// should only be written while no request is in flight.
// Reset (rst_n low, synchronous) restores register defaults, clears the tick
// phase, error history and drive, and empties the pipeline.
// A stalled receiver holds the result; each stage keeps working until the
// stage ahead of it is full, after which in_ready drops for controller ticks.
`timescale 1ns / 1ps
module motor_speed_incremental_pid #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COUNT_WIDTH-1:0]         in_encoder_count,
  input  logic signed [msip_pkg::TGT_W-1:0]     in_speed_target,
  input  logic                                  in_park,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [msip_pkg::PWM_W-1:0]            out_pwm_forward,
  output logic [msip_pkg::PWM_W-1:0]            out_pwm_reverse,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [msip_pkg::CFG_IW-1:0]           cfg_index,
  input  logic [msip_pkg::CFG_DW-1:0]           cfg_data
);
  import msip_pkg::*;

  localparam int RAW_W = (COUNT_WIDTH + 6 > ERR_W + 1) ? COUNT_WIDTH + 6 : ERR_W + 1;
  localparam int D1_W  = ERR_W + 1;
  localparam int D2_W  = ERR_W + 2;
  localparam int PP_W  = GAIN_W + D1_W;
  localparam int PI_W  = GAIN_W + ERR_W;
  localparam int PD_W  = GAIN_W + D2_W;
  localparam logic signed [RAW_W-1:0] RAW_HI = RAW_W'(ERR_MAX);
  localparam logic signed [RAW_W-1:0] RAW_LO = RAW_W'(ERR_MIN);

  // configuration registers
  logic signed [GAIN_W-1:0] gain_prop_r, gain_integ_r, gain_deriv_r;
  logic [LIMIT_W-1:0]       drive_limit_r;
  logic [DIV_W-1:0]         update_div_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_prop_r   <= GAIN_PROP_RST;
      gain_integ_r  <= GAIN_INTEG_RST;
      gain_deriv_r  <= GAIN_DERIV_RST;
      drive_limit_r <= LIMIT_RST;
      update_div_r  <= DIV_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GAIN_PROP:  gain_prop_r   <= signed'(cfg_data[GAIN_W-1:0]);
        CFG_GAIN_INTEG: gain_integ_r  <= signed'(cfg_data[GAIN_W-1:0]);
        CFG_GAIN_DERIV: gain_deriv_r  <= signed'(cfg_data[GAIN_W-1:0]);
        CFG_DRIVE_LIM:  drive_limit_r <= cfg_data[LIMIT_W-1:0];
        CFG_UPD_DIV:    update_div_r  <= cfg_data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic v0_r, v1_r, v2_r, v3_r, out_valid_r;
  logic rdy0, rdy1, rdy2, rdy3, rdy_out;

  assign rdy_out = !out_valid_r || out_ready;
  assign rdy3    = !v3_r || rdy_out;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign rdy0    = !v0_r || rdy1;

  // tick prescaler
  logic [DIV_W-1:0] phase_r, phase_inc, phase_nxt;
  logic             fire;
  logic             in_fire;

  assign phase_inc = phase_r + DIV_W'(1);
  assign fire      = (phase_inc >= update_div_r);
  assign in_ready  = rdy0 || !fire;
  assign in_fire   = in_valid && in_ready;
  assign phase_nxt = fire ? '0 : phase_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
    end
  end

  // stage 0: input register
  logic signed [COUNT_WIDTH-1:0] s0_count_r;
  logic signed [TGT_W-1:0]       s0_target_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (rdy0) begin
      v0_r <= in_fire && fire;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_fire && fire) begin
      s0_count_r  <= in_encoder_count;
      s0_target_r <= in_park ? '0 : in_speed_target;
    end
  end

  // stage 1: error and history
  logic signed [RAW_W-1:0] cnt_x, tgt_x, raw_err;
  logic signed [ERR_W-1:0] err_new;
  logic signed [ERR_W-1:0] err_now_r, err_prev_r, err_prev2_r;
  logic signed [D1_W-1:0]  d1_nxt, s1_d1_r;
  logic signed [D2_W-1:0]  d2_nxt, s1_d2_r;
  logic signed [ERR_W-1:0] s1_e_r;

  always_comb begin
    cnt_x   = RAW_W'(s0_count_r);
    tgt_x   = RAW_W'(s0_target_r);
    raw_err = tgt_x + cnt_x * RAW_W'(MEAS_SCALE);
    if (raw_err > RAW_HI) begin
      err_new = ERR_W'(RAW_HI);
    end else if (raw_err < RAW_LO) begin
      err_new = ERR_W'(RAW_LO);
    end else begin
      err_new = ERR_W'(raw_err);
    end
    d1_nxt = D1_W'(err_new) - D1_W'(err_now_r);
    d2_nxt = D2_W'(err_new) - (D2_W'(err_now_r) <<< 1) + D2_W'(err_prev_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      err_now_r   <= '0;
      err_prev_r  <= '0;
      err_prev2_r <= '0;
    end else if (rdy1) begin
      v1_r <= v0_r;
      if (v0_r) begin
        err_prev2_r <= err_prev_r;
        err_prev_r  <= err_now_r;
        err_now_r   <= err_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && v0_r) begin
      s1_d1_r <= d1_nxt;
      s1_d2_r <= d2_nxt;
      s1_e_r  <= err_new;
    end
  end

  // stage 2: gain products
  logic signed [PP_W-1:0] s2_pp_r;
  logic signed [PI_W-1:0] s2_pi_r;
  logic signed [PD_W-1:0] s2_pd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      s2_pp_r <= PP_W'(gain_prop_r) * PP_W'(s1_d1_r);
      s2_pi_r <= PI_W'(gain_integ_r) * PI_W'(s1_e_r);
      s2_pd_r <= PD_W'(gain_deriv_r) * PD_W'(s1_d2_r);
    end
  end

  // stage 3: step sum
  logic signed [STEP_W-1:0] s3_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      s3_step_r <= STEP_W'(s2_pp_r) + STEP_W'(s2_pi_r) + STEP_W'(s2_pd_r);
    end
  end

  // stage 4: accumulate, clamp, split by sign
  logic signed [ACC_W-1:0] accum_r, accum_nxt;
  logic signed [SUM_W-1:0] acc_sum, lim_pos, acc_clamp, acc_neg;
  logic [PWM_W-1:0]        fwd_nxt, rev_nxt, pwm_fwd_r, pwm_rev_r;

  always_comb begin
    acc_sum = SUM_W'(accum_r) + SUM_W'(s3_step_r);
    lim_pos = signed'(SUM_W'({drive_limit_r, FRAC_BITS'(0)}));
    if (acc_sum > lim_pos) begin
      acc_clamp = lim_pos;
    end else if (acc_sum < -lim_pos) begin
      acc_clamp = -lim_pos;
    end else begin
      acc_clamp = acc_sum;
    end
    accum_nxt = ACC_W'(acc_clamp);
    acc_neg   = -acc_clamp;
    if (acc_clamp < 0) begin
      fwd_nxt = '0;
      rev_nxt = acc_neg[FRAC_BITS +: PWM_W];
    end else begin
      fwd_nxt = acc_clamp[FRAC_BITS +: PWM_W];
      rev_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      accum_r     <= '0;
    end else if (rdy_out) begin
      out_valid_r <= v3_r;
      if (v3_r) begin
        accum_r <= accum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && v3_r) begin
      pwm_fwd_r <= fwd_nxt;
      pwm_rev_r <= rev_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pwm_forward = pwm_fwd_r;
  assign out_pwm_reverse = pwm_rev_r;

endmodule

>>> hw/rtl/msip_checker.sv
// Port-level assertion checker for the motor speed incremental PID block.
`timescale 1ns / 1ps
`include "motor_speed_incremental_pid_macros.svh"
module msip_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [msip_pkg::PWM_W-1:0]   out_pwm_forward,
  input logic [msip_pkg::PWM_W-1:0]   out_pwm_reverse,
  input logic                         cfg_ready
);
  import msip_pkg::*;

  // only one PWM channel may carry duty at a time
  `MSIP_ASSERT(a_one_channel, clk, rst_n, out_valid |-> (out_pwm_forward == '0 || out_pwm_reverse == '0), "both PWM channels nonzero")
  // reset empties the pipeline
  `MSIP_ASSERT_NR(a_rst_empty, clk, !rst_n |=> !out_valid, "result present after reset")
  // an empty pipeline after reset takes a request
  `MSIP_ASSERT_NR(a_rst_ready, clk, !rst_n |=> in_ready, "input not ready after reset")
  // a stalled result holds
  `MSIP_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_pwm_forward) && $stable(out_pwm_reverse), "stalled result changed")
  // configuration never back-pressures
  `MSIP_ASSERT(a_cfg_ready, clk, rst_n, cfg_ready, "config port not ready")

endmodule

bind motor_speed_incremental_pid msip_checker u_msip_checker (.*);
